// ===== rtl/core/c8cf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8cf_pkg: shared types and constants for the CHIP-8 control flow step unit
// Opcode names, fixed widths, the execute result record and the BCD helper.
// ----------------------------------------------------------------------------
package c8cf_pkg;

  localparam int REG_COUNT = 16;
  localparam int REG_AW = 4;
  localparam int INSTR_W = 16;
  localparam int ADDR_W = 16;
  localparam int LEVEL_W = 5;
  localparam int TDATA_OUT_W = 64;

  localparam logic [15:0] ENTRY_RESET = 16'h0200;
  localparam logic [7:0] KK_RET = 8'hEE;
  localparam logic [7:0] KK_BCD = 8'h33;

  typedef enum logic [3:0] {
    OP_SYS  = 4'h0,
    OP_JP   = 4'h1,
    OP_CALL = 4'h2,
    OP_SE   = 4'h3,
    OP_SNE  = 4'h4,
    OP_SER  = 4'h5,
    OP_LD   = 4'h6,
    OP_ADD  = 4'h7,
    OP_SNER = 4'h9,
    OP_LDI  = 4'hA,
    OP_JPV  = 4'hB,
    OP_MISC = 4'hF
  } opcode_t;

  typedef struct packed {
    logic [15:0] pc_next;
    logic [15:0] index_next;
    logic        reg_we;
    logic [7:0]  reg_wdata;
    logic        push;
    logic        stack_error;
    logic        write_valid;
    logic [15:0] write_address;
    logic [3:0]  write_data;
    logic        last;
  } exec_result_t;

  // hundreds in [11:8], tens in [7:4], ones in [3:0]
  function automatic logic [11:0] bcd_digits(input logic [7:0] v);
    logic [3:0] h;
    logic [6:0] r;
    logic [3:0] t;
    logic [6:0] o;
    if (v >= 8'd200) begin
      h = 4'd2;
      r = 7'(v - 8'd200);
    end else if (v >= 8'd100) begin
      h = 4'd1;
      r = 7'(v - 8'd100);
    end else begin
      h = 4'd0;
      r = v[6:0];
    end
    t = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (r >= 7'(i * 10)) begin
        t = 4'(i);
      end
    end
    o = r - 7'(t) * 7'd10;
    return {h, t, o[3:0]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/c8cf_regfile.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8cf_regfile: data register memory
// One write port, two registered read ports with write-first bypass. Per-entry
// valid bits make never-written registers read as zero after reset.
// ----------------------------------------------------------------------------
module c8cf_regfile
  import c8cf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              we,
  input  wire logic [REG_AW-1:0] waddr,
  input  wire logic [7:0]        wdata,
  input  wire logic              re,
  input  wire logic [REG_AW-1:0] raddr_a,
  input  wire logic [REG_AW-1:0] raddr_b,
  output logic      [7:0]        rdata_a,
  output logic      [7:0]        rdata_b
);

  logic [7:0] mem [REG_COUNT];
  logic [REG_COUNT-1:0] written;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      if (we && waddr == raddr_a) begin
        rdata_a <= wdata;
      end else begin
        rdata_a <= written[raddr_a] ? mem[raddr_a] : 8'h00;
      end
      if (we && waddr == raddr_b) begin
        rdata_b <= wdata;
      end else begin
        rdata_b <= written[raddr_b] ? mem[raddr_b] : 8'h00;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/c8cf_stack.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8cf_stack: return address memory
// One write port and one registered read port with write-first bypass.
// ----------------------------------------------------------------------------
module c8cf_stack
  import c8cf_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [ADDR_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [ADDR_W-1:0] rdata
);

  logic [ADDR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      if (we && waddr == raddr) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/c8cf_exec.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8cf_exec: instruction execute logic
// Decodes one instruction with its operands and produces the new architectural
// values, the write-back requests and the result fields for one BCD digit.
// ----------------------------------------------------------------------------
module c8cf_exec
  import c8cf_pkg::*;
#(
  parameter int STACK_DEPTH = 16,
  parameter int SPW = 5
) (
  input  wire logic [INSTR_W-1:0] instr,
  input  wire logic [7:0]         va,
  input  wire logic [7:0]         vb,
  input  wire logic [ADDR_W-1:0]  pc,
  input  wire logic [ADDR_W-1:0]  index,
  input  wire logic [SPW-1:0]     sp,
  input  wire logic [ADDR_W-1:0]  stack_top,
  input  wire logic [1:0]         digit,
  output exec_result_t            res,
  output logic      [SPW-1:0]     sp_next
);

  logic [3:0]  x;
  logic [7:0]  kk;
  logic [11:0] nnn;
  logic        is_bcd;
  logic [11:0] bcd;

  assign x = instr[11:8];
  assign kk = instr[7:0];
  assign nnn = instr[11:0];
  assign is_bcd = (instr[15:12] == OP_MISC) && (kk == KK_BCD);
  assign bcd = bcd_digits(va);

  always_comb begin
    res = '0;
    res.pc_next = pc + 16'd2;
    res.index_next = index;
    res.reg_wdata = kk;
    sp_next = sp;
    unique case (instr[15:12])
      OP_SYS: begin
        if (x == 4'h0 && kk == KK_RET) begin
          if (sp == '0) begin
            res.stack_error = 1'b1;
          end else begin
            sp_next = sp - SPW'(1);
            res.pc_next = stack_top + 16'd2;
          end
        end
      end
      OP_JP: begin
        res.pc_next = {4'h0, nnn};
      end
      OP_CALL: begin
        if (sp >= SPW'(STACK_DEPTH)) begin
          res.stack_error = 1'b1;
        end else begin
          res.push = 1'b1;
          sp_next = sp + SPW'(1);
        end
        res.pc_next = {4'h0, nnn};
      end
      OP_SE: begin
        if (va == kk) res.pc_next = pc + 16'd4;
      end
      OP_SNE: begin
        if (va != kk) res.pc_next = pc + 16'd4;
      end
      OP_SER: begin
        if (va == vb) res.pc_next = pc + 16'd4;
      end
      OP_LD: begin
        res.reg_we = 1'b1;
      end
      OP_ADD: begin
        res.reg_we = 1'b1;
        res.reg_wdata = va + kk;
      end
      OP_SNER: begin
        if (va != vb) res.pc_next = pc + 16'd4;
      end
      OP_LDI: begin
        res.index_next = {4'h0, nnn};
      end
      OP_JPV: begin
        res.pc_next = {4'h0, nnn} + {8'h00, vb};
      end
      default: begin
      end
    endcase

    // later digits of a BCD store see the already advanced PC
    if (is_bcd && digit != 2'd0) begin
      res.pc_next = pc;
    end
    res.write_valid = is_bcd;
    res.last = !is_bcd || digit == 2'd2;
    if (is_bcd) begin
      res.write_address = index + {14'h0, digit};
      case (digit)
        2'd0: res.write_data = bcd[11:8];
        2'd1: res.write_data = bcd[7:4];
        default: res.write_data = bcd[3:0];
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/chip8_control_flow_step_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chip8_control_flow_step_unit: CHIP-8 control flow and register step unit
//
//   channel   direction  handshake             payload
//   s_axis    in         tvalid / tready       tdata[15:0] instruction
//   m_axis    out        tvalid / tready       tdata fields, tlast = last
//   entry     in         entry_address_we      entry_address_wdata[15:0]
//
// An instruction is accepted while its register and stack reads are issued, and
// executes in the next cycle against the read data. Sustained rate is one
// instruction per cycle while the output is not stalled; Fx33 holds the execute
// stage until all three of its digits are written. Writes of one instruction are
// bypassed into the reads of the next. Reset leaves the data registers reading
// zero and the program counter at 0x200. A stalled output holds the execute stage.
// ----------------------------------------------------------------------------
module chip8_control_flow_step_unit
  import c8cf_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [15:0] instruction
  input  wire logic [INSTR_W-1:0]     s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [15:0] next_pc, [31:16] index_value, [36:32] stack_level, [37] write_valid,
  // [53:38] write_address, [57:54] write_data, [58] stack_error, [63:59] zero
  output logic      [TDATA_OUT_W-1:0] m_axis_tdata,
  output logic                        m_axis_tlast,
  input  wire logic                   entry_address_we,
  input  wire logic [ADDR_W-1:0]      entry_address_wdata
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [ADDR_W-1:0] pc;
  logic [ADDR_W-1:0] index;
  logic [SPW-1:0]    sp;
  logic [SPW-1:0]    sp_issue;
  logic [SPW-1:0]    sp_dec;
  logic [SPW-1:0]    ex_sp_next;

  logic               ex_valid;
  logic [INSTR_W-1:0] ex_instr;
  logic [1:0]         ex_digit;

  logic [7:0]        va;
  logic [7:0]        vb;
  logic [ADDR_W-1:0] stack_top;
  exec_result_t      res;

  logic out_free;
  logic emit;
  logic commit;
  logic accept;
  logic [LEVEL_W-1:0] level;
  logic [REG_AW-1:0]  raddr_b;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign emit = ex_valid && out_free;
  assign commit = emit && ex_digit == 2'd0;
  assign s_axis_tready = !ex_valid || (emit && res.last);
  assign accept = s_axis_tvalid && s_axis_tready;

  assign sp_issue = commit ? ex_sp_next : sp;
  assign sp_dec = sp_issue - SPW'(1);
  assign raddr_b = (s_axis_tdata[15:12] == OP_JPV) ? REG_AW'(0) : s_axis_tdata[7:4];

  c8cf_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .we      (commit && res.reg_we),
    .waddr   (ex_instr[11:8]),
    .wdata   (res.reg_wdata),
    .re      (accept),
    .raddr_a (s_axis_tdata[11:8]),
    .raddr_b (raddr_b),
    .rdata_a (va),
    .rdata_b (vb)
  );

  c8cf_stack #(
    .DEPTH (STACK_DEPTH),
    .AW    (SAW)
  ) u_stack (
    .clk   (clk),
    .we    (commit && res.push),
    .waddr (sp[SAW-1:0]),
    .wdata (pc),
    .re    (accept),
    .raddr (sp_dec[SAW-1:0]),
    .rdata (stack_top)
  );

  c8cf_exec #(
    .STACK_DEPTH (STACK_DEPTH),
    .SPW         (SPW)
  ) u_exec (
    .instr     (ex_instr),
    .va        (va),
    .vb        (vb),
    .pc        (pc),
    .index     (index),
    .sp        (sp),
    .stack_top (stack_top),
    .digit     (ex_digit),
    .res       (res),
    .sp_next   (ex_sp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ENTRY_RESET;
      index <= '0;
      sp <= '0;
    end else if (entry_address_we) begin
      pc <= entry_address_wdata;
    end else if (commit) begin
      pc <= res.pc_next;
      index <= res.index_next;
      sp <= ex_sp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
      ex_digit <= 2'd0;
    end else if (emit && !res.last) begin
      ex_digit <= ex_digit + 2'd1;
    end else if (s_axis_tready) begin
      ex_valid <= s_axis_tvalid;
      ex_digit <= 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ex_instr <= s_axis_tdata;
    end
  end

  if (SPW >= LEVEL_W) begin : g_level_trunc
    assign level = ex_sp_next[LEVEL_W-1:0];
  end else begin : g_level_ext
    assign level = {{(LEVEL_W - SPW){1'b0}}, ex_sp_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= {5'b0, res.stack_error, res.write_data, res.write_address,
                       res.write_valid, level, res.index_next, res.pc_next};
      m_axis_tlast <= res.last;
    end
  end

endmodule
`default_nettype wire
